### src/bitstream_field_reader_assert.svh
// Assertion macros for the bitstream field reader.
// Included by bfr_engine, which checks its own logic; no other dependencies.
`ifndef BITSTREAM_FIELD_READER_ASSERT_SVH
`define BITSTREAM_FIELD_READER_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is low
`define BFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also runs during reset
`define BFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/bfr_pkg.sv
// Shared constants, codes and types of the bitstream field reader.
// No dependencies; every other file but the assertion header imports it.
package bfr_pkg;

    // Field widths
    localparam int OPCODE_W     = 2;
    localparam int LOAD_ADDR_W  = 12;
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 6;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 32;
    localparam int BYTE_COUNT_W = 13;
    localparam int START_BIT_W  = 15;
    localparam int DATA_W       = 32;
    localparam int PADDR_W      = 4;

    // Defaults of the top-level parameters
    localparam int DEF_BUFFER_BYTES  = 4096;
    localparam int DEF_MAX_READ_BITS = 32;

    // Bit offset inside a byte and bits per byte
    localparam logic [2:0] BIT_IN_BYTE_MASK = 3'h7;
    localparam logic [3:0] BYTE_BITS        = 4'd8;

    // Item opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PEEK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

    // Register indexes (word address bits)
    localparam logic [1:0] REG_BYTE_COUNT = 2'd0;
    localparam logic [1:0] REG_START_BIT  = 2'd1;
    localparam logic [1:0] REG_BIT_ORDER  = 2'd2;

    // Configuration seen by the gather engine
    typedef struct packed {
        logic [BYTE_COUNT_W-1:0] byte_count;
        logic                    bit_order;
        logic                    start_wr;
        logic [START_BIT_W-1:0]  start_bit;
    } t_cfg;

endpackage

### src/bfr_in_if.sv
// Input channel of the bitstream field reader: valid/ready plus item fields.
// Depends on bfr_pkg.
interface bfr_in_if
    import bfr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [BYTE_W-1:0]      load_byte;
    logic [COUNT_W-1:0]     bit_count;

    modport source (output valid, opcode, load_address, load_byte, bit_count, input ready);
    modport sink (input valid, opcode, load_address, load_byte, bit_count, output ready);
endinterface

### src/bfr_out_if.sv
// Result channel of the bitstream field reader: valid/ready plus result fields.
// Depends on bfr_pkg.
interface bfr_out_if
    import bfr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] bits_delivered;

    modport source (output valid, value, bits_delivered, input ready);
    modport sink (input valid, value, bits_delivered, output ready);
endinterface

### src/bfr_regs.sv
// APB-style configuration registers of the bitstream field reader.
// Depends on bfr_pkg; feeds a t_cfg struct to the gather engine.
module bfr_regs
    import bfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [BYTE_COUNT_W-1:0] r_byte_count;
    logic [START_BIT_W-1:0]  r_start_bit;
    logic                    r_bit_order;
    logic                    wr_en;
    logic [1:0]              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_start_bit  <= '0;
            r_bit_order  <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BYTE_COUNT: r_byte_count <= pwdata[BYTE_COUNT_W-1:0];
                REG_START_BIT:  r_start_bit  <= pwdata[START_BIT_W-1:0];
                REG_BIT_ORDER:  r_bit_order  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (reg_idx)
            REG_BYTE_COUNT: prdata = {{(DATA_W-BYTE_COUNT_W){1'b0}}, r_byte_count};
            REG_START_BIT:  prdata = {{(DATA_W-START_BIT_W){1'b0}}, r_start_bit};
            REG_BIT_ORDER:  prdata = {{(DATA_W-1){1'b0}}, r_bit_order};
            default:        prdata = '0;
        endcase
    end

    // Start-bit writes reload the position in the same edge
    assign o_cfg.byte_count = r_byte_count;
    assign o_cfg.bit_order  = r_bit_order;
    assign o_cfg.start_wr   = wr_en && (reg_idx == REG_START_BIT);
    assign o_cfg.start_bit  = pwdata[START_BIT_W-1:0];

endmodule

### src/bfr_engine.sv
// Byte memory, bit position and byte-by-byte gather sequencer.
// Depends on bfr_pkg, bfr_in_if, bfr_out_if and the assertion macro header.
`include "bitstream_field_reader_assert.svh"
module bfr_engine
    import bfr_pkg::*;
#(
    parameter int BUFFER_BYTES  = DEF_BUFFER_BYTES,
    parameter int MAX_READ_BITS = DEF_MAX_READ_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    bfr_in_if.sink     i_in,
    bfr_out_if.source  o_out
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [POS_W-1:0]   BUF_LIMIT = POS_W'(BUFFER_BYTES);
    localparam logic [COUNT_W-1:0] MAX_BITS  = COUNT_W'(MAX_READ_BITS);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state              r_state;
    logic [POS_W-1:0]    r_pos;
    logic [COUNT_W-1:0]  r_want;
    logic [COUNT_W-1:0]  r_have;
    logic                r_is_read;
    logic [VALUE_W-1:0]  r_acc;
    logic                r_pend;
    logic [2:0]          r_pskip;
    logic [3:0]          r_ptake;
    logic [BYTE_W-1:0]   r_rdata;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [COUNT_W-1:0]  r_out_got;

    logic [BYTE_W-1:0]   mem [BUFFER_BYTES];

    logic                in_fire;
    logic                out_free;
    logic                mem_we;
    logic [POS_W-1:0]    wr_addr;
    logic [COUNT_W-1:0]  sat_count;
    logic                is_bits_op;
    logic [POS_W-1:0]    limit;
    logic [POS_W-1:0]    bit_addr;
    logic [POS_W-4:0]    byte_addr;
    logic [2:0]          skip;
    logic                in_range;
    logic                issue;
    logic [COUNT_W-1:0]  remain;
    logic [3:0]          avail;
    logic [3:0]          take;
    logic                finish;
    logic                pos_adv;
    logic [BYTE_W-1:0]   shl;
    logic [3:0]          rsh;
    logic [BYTE_W-1:0]   chunk;
    logic [VALUE_W-1:0]  n_acc;
    logic [COUNT_W-1:0]  n_have;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;

    // Decode the accepted item
    assign wr_addr    = {{(POS_W-LOAD_ADDR_W){1'b0}}, i_in.load_address};
    assign mem_we     = in_fire && (i_in.opcode == OP_LOAD) && (wr_addr < BUF_LIMIT);
    assign sat_count  = (i_in.bit_count > MAX_BITS) ? MAX_BITS : i_in.bit_count;
    assign is_bits_op = (i_in.opcode == OP_PEEK) || (i_in.opcode == OP_READ);

    // Next byte to fetch and how many of its bits to take
    assign limit     = ({{(POS_W-BYTE_COUNT_W){1'b0}}, i_cfg.byte_count} < BUF_LIMIT)
                     ? {{(POS_W-BYTE_COUNT_W){1'b0}}, i_cfg.byte_count} : BUF_LIMIT;
    assign bit_addr  = r_pos + {{(POS_W-COUNT_W){1'b0}}, r_have};
    assign byte_addr = bit_addr[POS_W-1:3];
    assign skip      = bit_addr[2:0] & BIT_IN_BYTE_MASK;
    assign in_range  = {3'b000, byte_addr} < limit;
    assign issue     = (r_state == S_RUN) && (r_have < r_want) && in_range;
    assign remain    = r_want - r_have;
    assign avail     = BYTE_BITS - {1'b0, skip};
    assign take      = (remain > {2'b00, avail}) ? avail : remain[3:0];
    assign n_have    = r_have + {2'b00, take};

    // Fold in the byte fetched last cycle
    assign shl   = r_rdata << r_pskip;
    assign rsh   = BYTE_BITS - r_ptake;
    assign chunk = i_cfg.bit_order ? ((r_rdata >> r_pskip) & (8'hFF >> rsh))
                                   : (shl >> rsh);
    assign n_acc = r_pend ? ((r_acc << r_ptake) | {{(VALUE_W-BYTE_W){1'b0}}, chunk})
                          : r_acc;

    assign finish  = (r_state == S_RUN) && !issue;
    assign pos_adv = finish && out_free && r_is_read;

    // Byte memory: one write port for loads, one read port for the gather
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr[AW-1:0]] <= i_in.load_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= mem[byte_addr[AW-1:0]];
        end
    end

    // Result valid: set on finish, clear on the result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer, bit position and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_want      <= '0;
            r_have      <= '0;
            r_is_read   <= 1'b0;
        end else begin
            if (i_cfg.start_wr) begin
                r_pos <= {{(POS_W-START_BIT_W){1'b0}}, i_cfg.start_bit};
            end else if (pos_adv) begin
                r_pos <= r_pos + {{(POS_W-COUNT_W){1'b0}}, r_want};
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_want    <= is_bits_op ? sat_count : '0;
                        r_is_read <= (i_in.opcode == OP_READ);
                        r_have    <= '0;
                        r_acc     <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_acc  <= n_acc;
                    r_pend <= issue;
                    if (issue) begin
                        r_pskip <= skip;
                        r_ptake <= take;
                        r_have  <= n_have;
                    end else if (out_free) begin
                        r_out_value <= n_acc;
                        r_out_got   <= r_have;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_out_value;
    assign o_out.bits_delivered = r_out_got;

    // Checks on the sequencer
    `BFR_ASSERT(a_have_le_want, i_clk, i_rst_n, (r_state == S_RUN) |-> (r_have <= r_want), "gathered more bits than requested")
    `BFR_ASSERT(a_idle_no_pend, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_pend, "byte fetch left pending in idle")
    `BFR_ASSERT(a_pend_take, i_clk, i_rst_n, r_pend |-> ((r_ptake != 4'd0) && (r_ptake <= BYTE_BITS)), "bad chunk width")
    `BFR_ASSERT(a_pos_hold, i_clk, i_rst_n, (!i_cfg.start_wr && !pos_adv) |=> $stable(r_pos), "bit position moved without a read or start write")
    `BFR_ASSERT(a_got_max, i_clk, i_rst_n, r_out_valid |-> (r_out_got <= MAX_BITS), "delivered more bits than the maximum")
    `BFR_ASSERT_ALWAYS(a_reset_idle, i_clk, (!i_rst_n) |=> (r_state == S_IDLE), "sequencer not idle after reset")

endmodule

### src/bitstream_field_reader.sv
// Top level of the bitstream field reader: configuration registers and engine.
// Depends on bfr_pkg, bfr_in_if, bfr_out_if, bfr_regs and bfr_engine.
//
// Loads bytes into a BUFFER_BYTES-deep buffer and returns up to MAX_READ_BITS bits
// from the current bit position per peek or read; a read then advances the
// position by the requested count, saturated to MAX_READ_BITS. A load or an
// unused opcode returns a result with no bits. A peek or read fetches the
// buffer bytes that it touches, 0 to 5 with the default MAX_READ_BITS, one by
// one, since the single byte-wide memory read port delivers one byte per cycle;
// no new item is taken until the current one finishes. A finished result waits
// in an output register, so the next item is taken while it is still pending;
// that item cannot finish until the pending result is transferred. The buffer
// is not cleared at reset: bytes must be loaded before they are read. Writing
// start_bit reloads the bit position at once.
module bitstream_field_reader
    import bfr_pkg::*;
#(
    parameter int BUFFER_BYTES  = DEF_BUFFER_BYTES,
    parameter int MAX_READ_BITS = DEF_MAX_READ_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bfr_in_if.sink             i_in,
    bfr_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_cfg cfg;

    // Configuration registers
    bfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Byte memory and gather sequencer
    bfr_engine #(
        .BUFFER_BYTES  (BUFFER_BYTES),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
